[hw/rtl/triangle_rotate_project_viewport_assert.svh]
// assertion macros for the triangle transform block
`ifndef TRIANGLE_ROTATE_PROJECT_VIEWPORT_ASSERT_SVH
`define TRIANGLE_ROTATE_PROJECT_VIEWPORT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TRPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define TRPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TRPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TRPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/trpv_pkg.sv]
// shared types, constants and helpers of the triangle transform block
package trpv_pkg;

  // input transaction: three vertices, signed q8.8
  typedef struct packed {
    logic signed [15:0] vertex0_x;
    logic signed [15:0] vertex0_y;
    logic signed [15:0] vertex0_z;
    logic signed [15:0] vertex1_x;
    logic signed [15:0] vertex1_y;
    logic signed [15:0] vertex1_z;
    logic signed [15:0] vertex2_x;
    logic signed [15:0] vertex2_y;
    logic signed [15:0] vertex2_z;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [15:0] screen0_x;
    logic signed [15:0] screen0_y;
    logic signed [15:0] screen1_x;
    logic signed [15:0] screen1_y;
    logic signed [15:0] screen2_x;
    logic signed [15:0] screen2_y;
    logic signed [15:0] depth0;
    logic signed [15:0] depth1;
    logic signed [15:0] depth2;
    logic [2:0]         w_zero_mask;
  } out_t;

  // configuration register file contents
  typedef struct packed {
    logic [31:0]        rotate_z;
    logic [31:0]        rotate_x;
    logic signed [15:0] proj_x_scale;
    logic signed [15:0] proj_y_scale;
    logic signed [15:0] depth_scale;
    logic signed [15:0] depth_offset;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cfg_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_ROTATE_Z      = 3'd0,
    REG_ROTATE_X      = 3'd1,
    REG_PROJ_X_SCALE  = 3'd2,
    REG_PROJ_Y_SCALE  = 3'd3,
    REG_DEPTH_SCALE   = 3'd4,
    REG_DEPTH_OFFSET  = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } reg_idx_t;

  localparam int CFG_DATA_W = 32;

  // reset values
  localparam logic [31:0]        RST_ROTATE     = 32'h4000_0000;
  localparam logic signed [15:0] RST_PROJ_X     = 16'sd3840;
  localparam logic signed [15:0] RST_PROJ_Y     = 16'sd4096;
  localparam logic signed [15:0] RST_DEPTH_SCL  = 16'sd4096;
  localparam logic signed [15:0] RST_DEPTH_OFS  = -16'sd410;
  localparam logic [12:0]        RST_SCR_WIDTH  = 13'd256;
  localparam logic [12:0]        RST_SCR_HEIGHT = 13'd240;

  // scene push along z: 3.0 in q8.8
  localparam logic signed [15:0] Z_OFFSET = 16'sd768;

  // quotient magnitude bits, wide enough that clamping never changes a result
  localparam int QW      = 31;
  // divider stages: prepare, one per quotient bit, sign
  localparam int DIV_LAT = QW + 2;

  // saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

[hw/rtl/trpv_xform.sv]
// rotation, scene offset, projection and divider operand setup, six stages
module trpv_xform #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  trpv_pkg::in_t         in_data,
  input  trpv_pkg::cfg_t        cfg,
  output logic                  out_valid,
  output logic [COORD_BITS+19:0] num_mag [9],
  output logic [COORD_BITS-1:0]  den_mag [3],
  output logic                  num_neg [9],
  output logic [2:0]            wz_mask
);
  import trpv_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NW = COORD_BITS + 20;

  // saturate to the coordinate width
  function automatic logic signed [CB-1:0] sat_c(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (CB - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[CB-1:0];
    end else if (v < lo) begin
      return lo[CB-1:0];
    end else begin
      return v[CB-1:0];
    end
  endfunction

  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];
  logic signed [15:0] vz [3];
  logic signed [15:0] cz, sz, cx, sx;

  logic [5:0] vld_r;

  // stage 1: z rotation products
  logic signed [31:0] a_xc_r [3], a_ys_r [3], a_xs_r [3], a_yc_r [3];
  logic signed [31:0] a_xc_nxt [3], a_ys_nxt [3], a_xs_nxt [3], a_yc_nxt [3];
  logic signed [15:0] a_z_r [3];
  // stage 2: z rotation result
  logic signed [CB-1:0] b_x1_r [3], b_y1_r [3], b_x1_nxt [3], b_y1_nxt [3];
  logic signed [15:0]   b_z_r [3];
  // stage 3: x rotation products
  logic signed [CB+15:0] c_yc_r [3], c_ys_r [3], c_yc_nxt [3], c_ys_nxt [3];
  logic signed [31:0]    c_zs_r [3], c_zc_r [3], c_zs_nxt [3], c_zc_nxt [3];
  logic signed [CB-1:0]  c_x1_r [3];
  // stage 4: x rotation result and scene offset
  logic signed [CB-1:0] d_x2_r [3], d_y2_r [3], d_z3_r [3];
  logic signed [CB-1:0] d_y2_nxt [3], d_z3_nxt [3];
  // stage 5: projection products
  logic signed [CB+15:0] e_px_r [3], e_py_r [3], e_pd_r [3];
  logic signed [CB+15:0] e_px_nxt [3], e_py_nxt [3], e_pd_nxt [3];
  logic signed [CB-1:0]  e_z3_r [3];
  // stage 6: divider operands
  logic [NW-1:0] f_num_r [9], f_num_nxt [9];
  logic [CB-1:0] f_den_r [3], f_den_nxt [3];
  logic          f_neg_r [9], f_neg_nxt [9];
  logic [2:0]    f_wz_r, f_wz_nxt;

  assign vx[0] = in_data.vertex0_x;
  assign vy[0] = in_data.vertex0_y;
  assign vz[0] = in_data.vertex0_z;
  assign vx[1] = in_data.vertex1_x;
  assign vy[1] = in_data.vertex1_y;
  assign vz[1] = in_data.vertex1_z;
  assign vx[2] = in_data.vertex2_x;
  assign vy[2] = in_data.vertex2_y;
  assign vz[2] = in_data.vertex2_z;

  assign cz = cfg.rotate_z[31:16];
  assign sz = cfg.rotate_z[15:0];
  assign cx = cfg.rotate_x[31:16];
  assign sx = cfg.rotate_x[15:0];

  // per-vertex datapath of all six stages
  always_comb begin
    logic signed [63:0] t0, t1, pd, nx, ny, nd, den, ud;
    logic signed [63:0] n [3];
    logic signed [CB-1:0] z2;
    logic wz, den_neg;
    for (int k = 0; k < 3; k++) begin
      a_xc_nxt[k] = vx[k] * cz;
      a_ys_nxt[k] = vy[k] * sz;
      a_xs_nxt[k] = vx[k] * sz;
      a_yc_nxt[k] = vy[k] * cz;

      t0 = 64'(a_xc_r[k]) - 64'(a_ys_r[k]) + 64'sd8192;
      t1 = 64'(a_xs_r[k]) + 64'(a_yc_r[k]) + 64'sd8192;
      b_x1_nxt[k] = sat_c(t0 >>> 14);
      b_y1_nxt[k] = sat_c(t1 >>> 14);

      c_yc_nxt[k] = b_y1_r[k] * cx;
      c_ys_nxt[k] = b_y1_r[k] * sx;
      c_zs_nxt[k] = b_z_r[k] * sx;
      c_zc_nxt[k] = b_z_r[k] * cx;

      t0 = 64'(c_yc_r[k]) - 64'(c_zs_r[k]) + 64'sd8192;
      t1 = 64'(c_ys_r[k]) + 64'(c_zc_r[k]) + 64'sd8192;
      d_y2_nxt[k] = sat_c(t0 >>> 14);
      z2 = sat_c(t1 >>> 14);
      d_z3_nxt[k] = sat_c(64'(z2) + 64'(Z_OFFSET));

      e_px_nxt[k] = d_x2_r[k] * cfg.proj_x_scale;
      e_py_nxt[k] = d_y2_r[k] * cfg.proj_y_scale;
      e_pd_nxt[k] = d_z3_r[k] * cfg.depth_scale;

      // w of zero: undivided values through a divide by one
      pd = 64'(e_pd_r[k]) + (64'(cfg.depth_offset) <<< 8);
      wz = (e_z3_r[k] == '0);
      nx = wz ? ((64'(e_px_r[k]) + 64'sd8) >>> 4) : (64'(e_px_r[k]) <<< 4);
      ny = wz ? ((64'(e_py_r[k]) + 64'sd8) >>> 4) : (64'(e_py_r[k]) <<< 4);
      nd = wz ? ((pd + 64'sd32) >>> 6) : (pd <<< 2);
      den = wz ? 64'sd1 : 64'(e_z3_r[k]);
      den_neg = den[63];
      ud = den_neg ? -den : den;
      f_den_nxt[k] = ud[CB-1:0];
      f_wz_nxt[k] = wz;
      n[0] = nx;
      n[1] = ny;
      n[2] = nd;
      for (int q = 0; q < 3; q++) begin
        f_neg_nxt[3*k+q] = n[q][63] ^ den_neg;
        t0 = n[q][63] ? -n[q] : n[q];
        f_num_nxt[3*k+q] = t0[NW-1:0];
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_xc_r[k] <= a_xc_nxt[k];
        a_ys_r[k] <= a_ys_nxt[k];
        a_xs_r[k] <= a_xs_nxt[k];
        a_yc_r[k] <= a_yc_nxt[k];
        a_z_r[k]  <= vz[k];
        b_x1_r[k] <= b_x1_nxt[k];
        b_y1_r[k] <= b_y1_nxt[k];
        b_z_r[k]  <= a_z_r[k];
        c_yc_r[k] <= c_yc_nxt[k];
        c_ys_r[k] <= c_ys_nxt[k];
        c_zs_r[k] <= c_zs_nxt[k];
        c_zc_r[k] <= c_zc_nxt[k];
        c_x1_r[k] <= b_x1_r[k];
        d_x2_r[k] <= c_x1_r[k];
        d_y2_r[k] <= d_y2_nxt[k];
        d_z3_r[k] <= d_z3_nxt[k];
        e_px_r[k] <= e_px_nxt[k];
        e_py_r[k] <= e_py_nxt[k];
        e_pd_r[k] <= e_pd_nxt[k];
        e_z3_r[k] <= d_z3_r[k];
        f_den_r[k] <= f_den_nxt[k];
      end
      for (int j = 0; j < 9; j++) begin
        f_num_r[j] <= f_num_nxt[j];
        f_neg_r[j] <= f_neg_nxt[j];
      end
      f_wz_r <= f_wz_nxt;
    end
  end

  assign out_valid = vld_r[5];
  assign num_mag   = f_num_r;
  assign den_mag   = f_den_r;
  assign num_neg   = f_neg_r;
  assign wz_mask   = f_wz_r;

endmodule

[hw/rtl/trpv_div.sv]
// pipelined restoring divider, one quotient bit per stage, rounded and clamped
module trpv_div #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [COORD_BITS+19:0]       num_mag,
  input  logic [COORD_BITS-1:0]        den_mag,
  input  logic                         neg,
  output logic signed [trpv_pkg::QW:0] quo
);
  import trpv_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int NW = COORD_BITS + 20;

  logic [CB-1:0] rem_r [QW+1], rem_nxt [QW+1];
  logic [CB-1:0] den_r [QW+1], den_nxt [QW+1];
  logic [QW-1:0] low_r [QW+1], low_nxt [QW+1];
  logic [QW-1:0] q_r [QW+1], q_nxt [QW+1];
  logic          ovf_r [QW+1], ovf_nxt [QW+1];
  logic          neg_r [QW+1], neg_nxt [QW+1];
  logic signed [QW:0] quo_r, quo_nxt;

  always_comb begin
    logic [NW-1:0] n0;
    logic [CB:0]   r2;
    logic          ge;
    logic [QW-1:0] qm;
    // prepare: add half the divisor, detect quotient overflow
    n0 = num_mag + NW'(den_mag >> 1);
    ovf_nxt[0] = (CB'(n0[NW-1:QW]) >= den_mag);
    rem_nxt[0] = ovf_nxt[0] ? '0 : CB'(n0[NW-1:QW]);
    low_nxt[0] = n0[QW-1:0];
    den_nxt[0] = den_mag;
    neg_nxt[0] = neg;
    q_nxt[0]   = '0;
    // one quotient bit per stage
    for (int i = 1; i <= QW; i++) begin
      r2 = {rem_r[i-1], low_r[i-1][QW-i]};
      ge = (r2 >= {1'b0, den_r[i-1]});
      rem_nxt[i] = ge ? CB'(r2 - {1'b0, den_r[i-1]}) : CB'(r2);
      q_nxt[i]   = {q_r[i-1][QW-2:0], ge};
      low_nxt[i] = low_r[i-1];
      den_nxt[i] = den_r[i-1];
      ovf_nxt[i] = ovf_r[i-1];
      neg_nxt[i] = neg_r[i-1];
    end
    // clamp and apply sign
    qm = ovf_r[QW] ? '1 : q_r[QW];
    quo_nxt = neg_r[QW] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_nxt[i];
        low_r[i] <= low_nxt[i];
        q_r[i]   <= q_nxt[i];
        ovf_r[i] <= ovf_nxt[i];
        neg_r[i] <= neg_nxt[i];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

[hw/rtl/trpv_view.sv]
// viewport mapping and final saturation, two stages
module trpv_view (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [trpv_pkg::QW:0] quo [9],
  input  logic [2:0]                   wz_mask,
  input  trpv_pkg::cfg_t               cfg,
  output logic                         out_valid,
  output trpv_pkg::out_t               out_data
);
  import trpv_pkg::*;

  logic               va_r, vb_r;
  logic [2:0]         ma_r;
  logic signed [47:0] tx_r [3], ty_r [3], tx_nxt [3], ty_nxt [3];
  logic signed [15:0] dd_r [3], dd_nxt [3];
  logic signed [15:0] sx [3], sy [3];
  out_t               ob_r, ob_nxt;

  // scale by viewport size, then round and saturate
  always_comb begin
    logic signed [33:0] nxv, nyv;
    for (int k = 0; k < 3; k++) begin
      nxv = 34'(quo[3*k]) + 34'sd65536;
      nyv = 34'(quo[3*k+1]) + 34'sd65536;
      tx_nxt[k] = nxv * $signed({1'b0, cfg.screen_width});
      ty_nxt[k] = nyv * $signed({1'b0, cfg.screen_height});
      dd_nxt[k] = sat16(48'(quo[3*k+2]));
      sx[k] = sat16((tx_r[k] + 48'sd4096) >>> 13);
      sy[k] = sat16((ty_r[k] + 48'sd4096) >>> 13);
    end
    ob_nxt.screen0_x   = sx[0];
    ob_nxt.screen0_y   = sy[0];
    ob_nxt.screen1_x   = sx[1];
    ob_nxt.screen1_y   = sy[1];
    ob_nxt.screen2_x   = sx[2];
    ob_nxt.screen2_y   = sy[2];
    ob_nxt.depth0      = dd_r[0];
    ob_nxt.depth1      = dd_r[1];
    ob_nxt.depth2      = dd_r[2];
    ob_nxt.w_zero_mask = ma_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      dd_r <= dd_nxt;
      ma_r <= wz_mask;
      ob_r <= ob_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = ob_r;

endmodule

[hw/rtl/triangle_rotate_project_viewport.sv]
// top level of the triangle rotate, project and viewport transform
//
// One transaction on the in_ channel carries a triangle of three signed q8.8
// vertices; one transaction on the out_ channel returns its three screen
// positions (signed q12.4), three depths (signed q2.14) and the w-zero mask.
// Both channels use valid/ready. Configuration is written through cfg_we,
// cfg_addr and cfg_wdata, one register per cycle; the user must write it
// only while the block is idle, which the block itself does not enforce. A
// triangle passes six stages of rotation and projection, 33 divider stages
// (one quotient bit per stage), two viewport stages and the output register;
// the per-bit divider chain sets the latency. Throughput is one triangle per
// cycle while the pipeline is not frozen. When the receiver stalls, the
// output register holds and one more result lands in a skid register;
// in_ready then drops and the whole pipeline freezes until the skid register
// drains, so nothing is lost or repeated. Synchronous active-low reset clears
// all valid bits and loads the register defaults; no memory needs clearing.
`include "triangle_rotate_project_viewport_assert.svh"

module triangle_rotate_project_viewport #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  trpv_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output trpv_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  trpv_pkg::reg_idx_t                    cfg_addr,
  input  logic [trpv_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import trpv_pkg::*;

  localparam int NW = COORD_BITS + 20;

  cfg_t cfg_r, cfg_nxt;
  logic en;

  logic                  xf_valid;
  logic [NW-1:0]         xf_num [9];
  logic [COORD_BITS-1:0] xf_den [3];
  logic                  xf_neg [9];
  logic [2:0]            xf_mask;

  logic signed [QW:0] dq [9];
  logic [DIV_LAT-1:0] dv_r;
  logic [2:0]         dm_r [DIV_LAT];

  logic vw_valid;
  out_t vw_data;

  logic out_valid_r, skid_v_r, take;
  out_t out_r, skid_r;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ROTATE_Z:      cfg_nxt.rotate_z      = cfg_wdata;
        REG_ROTATE_X:      cfg_nxt.rotate_x      = cfg_wdata;
        REG_PROJ_X_SCALE:  cfg_nxt.proj_x_scale  = cfg_wdata[15:0];
        REG_PROJ_Y_SCALE:  cfg_nxt.proj_y_scale  = cfg_wdata[15:0];
        REG_DEPTH_SCALE:   cfg_nxt.depth_scale   = cfg_wdata[15:0];
        REG_DEPTH_OFFSET:  cfg_nxt.depth_offset  = cfg_wdata[15:0];
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_wdata[12:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wdata[12:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_z      <= RST_ROTATE;
      cfg_r.rotate_x      <= RST_ROTATE;
      cfg_r.proj_x_scale  <= RST_PROJ_X;
      cfg_r.proj_y_scale  <= RST_PROJ_Y;
      cfg_r.depth_scale   <= RST_DEPTH_SCL;
      cfg_r.depth_offset  <= RST_DEPTH_OFS;
      cfg_r.screen_width  <= RST_SCR_WIDTH;
      cfg_r.screen_height <= RST_SCR_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline advances whenever the skid register is free
  assign en       = !skid_v_r;
  assign in_ready = en;

  trpv_xform #(.COORD_BITS(COORD_BITS)) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_valid (xf_valid),
    .num_mag   (xf_num),
    .den_mag   (xf_den),
    .num_neg   (xf_neg),
    .wz_mask   (xf_mask)
  );

  // nine dividers: x, y and depth of each vertex
  for (genvar j = 0; j < 9; j++) begin : g_div
    trpv_div #(.COORD_BITS(COORD_BITS)) u_div (
      .clk     (clk),
      .en      (en),
      .num_mag (xf_num[j]),
      .den_mag (xf_den[j/3]),
      .neg     (xf_neg[j]),
      .quo     (dq[j])
    );
  end

  // valid and mask follow the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DIV_LAT-2:0], xf_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= xf_mask;
      for (int i = 1; i < DIV_LAT; i++) begin
        dm_r[i] <= dm_r[i-1];
      end
    end
  end

  trpv_view u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_r[DIV_LAT-1]),
    .quo       (dq),
    .wz_mask   (dm_r[DIV_LAT-1]),
    .cfg       (cfg_r),
    .out_valid (vw_valid),
    .out_data  (vw_data)
  );

  // output register with skid stage
  assign take = out_ready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (take) begin
      out_valid_r <= skid_v_r || vw_valid;
      skid_v_r    <= 1'b0;
    end else if (vw_valid && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : vw_data;
    end else if (vw_valid && en) begin
      skid_r <= vw_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a full skid register always sits behind a pending result
  `TRPV_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_valid_r)
  // a held skid transaction is not dropped while the receiver stalls
  `TRPV_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_v_r && !out_ready, skid_v_r)

endmodule
